### sv/scle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor package
// Result kinds, line-end codes, control characters and the result record
// shared by the decoder and the top level.
// ----------------------------------------------------------------------------
package scle_pkg;

    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned CNT_W       = 3;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_LINE  = 2'd2,
        KIND_EOF   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_CR   = 2'd1,
        PEND_LF   = 2'd2
    } t_pend;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SUB   = 8'h1A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_value;
        logic [7:0] position;
        logic       last;
    } t_result;

    function automatic t_result make_result(t_kind kind, logic [7:0] ch, logic [7:0] pos);
        t_result r;
        r.kind       = kind;
        r.char_value = ch;
        r.position   = pos;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/scle_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor byte decoder
// Works out, for one received byte and the current line state, the whole
// list of results it causes and the next line state.
// ----------------------------------------------------------------------------
module scle_decode #(
    parameter int unsigned LINE_CAPACITY = 256,
    parameter int unsigned POS_W         = $clog2(LINE_CAPACITY)
) (
    input  wire logic [7:0]                                 i_rx_byte,
    input  wire logic [POS_W-1:0]                           i_line_pos,
    input  wire scle_pkg::t_pend                            i_pend,
    output scle_pkg::t_result [scle_pkg::MAX_RESULTS-1:0]   o_res,
    output logic [scle_pkg::CNT_W-1:0]                      o_count,
    output logic [POS_W-1:0]                                o_line_pos,
    output scle_pkg::t_pend                                 o_pend
);

    localparam logic [POS_W-1:0] WRAP_POS = POS_W'(LINE_CAPACITY - 3);

    logic is_pair;
    logic is_bs;
    logic is_eol;
    logic is_print;

    assign is_pair  = (i_pend == scle_pkg::PEND_CR && i_rx_byte == scle_pkg::CH_LF) ||
                      (i_pend == scle_pkg::PEND_LF && i_rx_byte == scle_pkg::CH_CR);
    assign is_bs    = (i_rx_byte == scle_pkg::CH_BS) || (i_rx_byte == scle_pkg::CH_DEL);
    assign is_eol   = (i_rx_byte == scle_pkg::CH_CR) || (i_rx_byte == scle_pkg::CH_LF);
    assign is_print = (i_rx_byte >= scle_pkg::CH_SPACE) && (i_rx_byte <= scle_pkg::CH_TILDE);

    always_comb begin
        o_res      = '0;
        o_count    = '0;
        o_line_pos = i_line_pos;
        o_pend     = scle_pkg::PEND_NONE;
        priority if (is_pair) begin
            o_count = '0;
        end else if (is_bs) begin
            if (i_line_pos != '0) begin
                o_line_pos = i_line_pos - 1'b1;
                o_res[0] = scle_pkg::make_result(scle_pkg::KIND_ECHO, scle_pkg::CH_BS, 8'd0);
                o_res[1] = scle_pkg::make_result(scle_pkg::KIND_ECHO, scle_pkg::CH_SPACE, 8'd0);
                o_res[2] = scle_pkg::make_result(scle_pkg::KIND_ECHO, scle_pkg::CH_BS, 8'd0);
                o_count  = 3'd3;
            end
        end else if (i_rx_byte == scle_pkg::CH_SUB) begin
            o_line_pos = '0;
            o_res[0]   = scle_pkg::make_result(scle_pkg::KIND_EOF, 8'd0, 8'd0);
            o_count    = 3'd1;
        end else if (is_eol) begin
            o_pend = (i_rx_byte == scle_pkg::CH_CR) ? scle_pkg::PEND_CR : scle_pkg::PEND_LF;
            o_res[0] = scle_pkg::make_result(scle_pkg::KIND_ECHO, i_rx_byte, 8'd0);
            o_res[1] = scle_pkg::make_result(scle_pkg::KIND_ECHO,
                (i_rx_byte == scle_pkg::CH_CR) ? scle_pkg::CH_LF : scle_pkg::CH_CR, 8'd0);
            o_res[2] = scle_pkg::make_result(scle_pkg::KIND_STORE, scle_pkg::CH_LF,
                8'(i_line_pos));
            o_res[3] = scle_pkg::make_result(scle_pkg::KIND_LINE, 8'd0,
                8'(i_line_pos + 1'b1));
            o_count    = 3'd4;
            o_line_pos = '0;
        end else if (is_print) begin
            o_res[0] = scle_pkg::make_result(scle_pkg::KIND_ECHO, i_rx_byte, 8'd0);
            o_res[1] = scle_pkg::make_result(scle_pkg::KIND_STORE, i_rx_byte, 8'(i_line_pos));
            o_count    = 3'd2;
            o_line_pos = i_line_pos + 1'b1;
            // The line is abandoned once it comes within two characters of capacity.
            if (i_line_pos >= WRAP_POS) begin
                o_res[2] = scle_pkg::make_result(scle_pkg::KIND_ECHO, scle_pkg::CH_CARET, 8'd0);
                o_res[3] = scle_pkg::make_result(scle_pkg::KIND_ECHO, scle_pkg::CH_CR, 8'd0);
                o_res[4] = scle_pkg::make_result(scle_pkg::KIND_ECHO, scle_pkg::CH_LF, 8'd0);
                o_count    = 3'd5;
                o_line_pos = '0;
            end
        end
        for (int i = 0; i < scle_pkg::MAX_RESULTS; i++) begin
            o_res[i].last = (scle_pkg::CNT_W'(i) == (o_count - 1'b1));
        end
    end

endmodule
`default_nettype wire

### sv/serial_console_line_editor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial console line editor
// Turns received console bytes into echo bytes, stored characters, line
// completion reports and end-of-input reports, one result per transfer.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_ready    i_rx_byte
//   output   out        o_valid / i_ready    o_kind, o_char_value, o_position, o_last
//
// A byte is decoded in the cycle it is taken and its results (up to five) are
// loaded into a short result queue; one result leaves per cycle in which i_ready
// is high. The next byte is taken in the same cycle as the final result of the
// previous one is transferred. Reset is synchronous and active low and empties
// the queue, clears the line position and forgets any pending line end.
// ----------------------------------------------------------------------------
module serial_console_line_editor_top #(
    parameter int unsigned LINE_CAPACITY = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_char_value,
    output logic [7:0]      o_position,
    output logic            o_last
);

    localparam int unsigned POS_W = $clog2(LINE_CAPACITY);

    logic [POS_W-1:0]                               r_line_pos;
    logic [POS_W-1:0]                               n_line_pos;
    scle_pkg::t_pend                                r_pend;
    scle_pkg::t_pend                                n_pend;
    scle_pkg::t_result [scle_pkg::MAX_RESULTS-1:0]  r_queue;
    scle_pkg::t_result [scle_pkg::MAX_RESULTS-1:0]  dec_res;
    logic [scle_pkg::CNT_W-1:0]                     r_count;
    logic [scle_pkg::CNT_W-1:0]                     dec_count;
    logic                                           in_xfer;
    logic                                           out_xfer;

    scle_decode #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .POS_W         (POS_W)
    ) u_decode (
        .i_rx_byte  (i_rx_byte),
        .i_line_pos (r_line_pos),
        .i_pend     (r_pend),
        .o_res      (dec_res),
        .o_count    (dec_count),
        .o_line_pos (n_line_pos),
        .o_pend     (n_pend)
    );

    assign o_valid  = (r_count != '0);
    assign out_xfer = o_valid && i_ready;
    assign o_ready  = (r_count == '0) || ((r_count == 3'd1) && i_ready);
    assign in_xfer  = i_valid && o_ready;

    assign o_kind       = r_queue[0].kind;
    assign o_char_value = r_queue[0].char_value;
    assign o_position   = r_queue[0].position;
    assign o_last       = r_queue[0].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_line_pos <= '0;
            r_pend     <= scle_pkg::PEND_NONE;
        end else begin
            if (in_xfer) begin
                r_count    <= dec_count;
                r_line_pos <= n_line_pos;
                r_pend     <= n_pend;
            end else if (out_xfer) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The queue head always drives the output; a transfer shifts the rest down.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_queue <= dec_res;
        end else if (out_xfer) begin
            for (int i = 0; i < scle_pkg::MAX_RESULTS - 1; i++) begin
                r_queue[i] <= r_queue[i+1];
            end
            r_queue[scle_pkg::MAX_RESULTS-1] <= '0;
        end
    end

endmodule
`default_nettype wire

### tb/sv/tb_serial_console_line_editor_top.sv
// ----------------------------------------------------------------------------
// Testbench for the serial console line editor
// Sends directed and random console bytes through the valid/ready input,
// predicts the echo, store, line and end-of-input results of each byte, and
// compares every result transfer field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_serial_console_line_editor_top;

    import scle_pkg::*;

    localparam int unsigned LINE_CAPACITY = 256;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_ITEMS  = 40;

    // Line discipline predictor and the queue of results still owed.
    class line_editor_scoreboard;
        t_result     owed_q[$];
        int unsigned line_pos;
        t_pend       line_end;
        int unsigned errors;
        int unsigned bytes_taken;
        int unsigned bytes_active;
        int unsigned overflows;
        int unsigned kind_count[4];

        function new();
            line_pos     = 0;
            line_end     = PEND_NONE;
            errors       = 0;
            bytes_taken  = 0;
            bytes_active = 0;
            overflows    = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void owe(t_kind kind, logic [7:0] ch, int unsigned pos);
            t_result r;
            r.kind       = kind;
            r.char_value = ch;
            r.position   = 8'(pos);
            r.last       = 1'b0;
            owed_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            t_pend       prev;
            int unsigned first;
            prev     = line_end;
            first    = owed_q.size();
            line_end = PEND_NONE;
            bytes_taken++;
            if ((prev == PEND_CR && b == CH_LF) || (prev == PEND_LF && b == CH_CR)) begin
                // Second half of a CR/LF or LF/CR pair: swallowed.
            end else if (b == CH_BS || b == CH_DEL) begin
                if (line_pos > 0) begin
                    line_pos--;
                    owe(KIND_ECHO, CH_BS, 0);
                    owe(KIND_ECHO, CH_SPACE, 0);
                    owe(KIND_ECHO, CH_BS, 0);
                end
            end else if (b == CH_SUB) begin
                line_pos = 0;
                owe(KIND_EOF, 8'h00, 0);
            end else if (b == CH_CR || b == CH_LF) begin
                line_end = (b == CH_CR) ? PEND_CR : PEND_LF;
                owe(KIND_ECHO, b, 0);
                owe(KIND_ECHO, (b == CH_CR) ? CH_LF : CH_CR, 0);
                owe(KIND_STORE, CH_LF, line_pos);
                owe(KIND_LINE, 8'h00, line_pos + 1);
                line_pos = 0;
            end else if (b >= CH_SPACE && b <= CH_TILDE) begin
                owe(KIND_ECHO, b, 0);
                owe(KIND_STORE, b, line_pos);
                line_pos++;
                // The line is abandoned just before the buffer would fill.
                if (line_pos + 2 >= LINE_CAPACITY) begin
                    owe(KIND_ECHO, CH_CARET, 0);
                    owe(KIND_ECHO, CH_CR, 0);
                    owe(KIND_ECHO, CH_LF, 0);
                    line_pos = 0;
                    overflows++;
                end
            end
            if (owed_q.size() > first) begin
                owed_q[owed_q.size() - 1].last = 1'b1;
                bytes_active++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            kind_count[got.kind]++;
            if (owed_q.size() == 0) begin
                $error("result with nothing owed: kind %0d char %02h position %0d last %0d",
                       got.kind, got.char_value, got.position, got.last);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.kind != want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.char_value != want.char_value) begin
                $error("char_value: expected %02h, actual %02h", want.char_value, got.char_value);
                errors++;
            end
            if (got.position != want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_char_value;
    logic [7:0] o_position;
    logic       o_last;

    line_editor_scoreboard sb = new();
    int unsigned burst_left = 0;
    int unsigned ready_cycle = 0;

    serial_console_line_editor_top #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_char_value(o_char_value),
        .o_position  (o_position),
        .o_last      (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Inputs only change on the falling edge, so values seen here are settled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_byte(i_rx_byte);
            end
            if (o_valid && i_ready) begin
                sb.check_result(t_result'({o_kind, o_char_value, o_position, o_last}));
            end
        end
    end

    // The receiver cycles through steady, sparse, periodic and random stalls.
    always @(negedge i_clk) begin
        ready_cycle++;
        case ((ready_cycle / 128) % 4)
            0: begin
                i_ready = 1'b1;
            end
            1: begin
                i_ready = ($urandom_range(0, 3) != 0);
            end
            2: begin
                i_ready = ((ready_cycle % 7) < 3);
            end
            default: begin
                i_ready = 1'($urandom_range(0, 1));
            end
        endcase
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("serial_console_line_editor_top: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_valid   = 1'b0;
                    i_rx_byte = 8'($urandom);
                end
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid    = 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] any_printable();
        return 8'($urandom_range(CH_SPACE, CH_TILDE));
    endfunction

    task automatic send_text(input int unsigned len);
        repeat (len) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
            end else begin
                send_byte(any_printable());
            end
        end
    endtask

    task automatic send_line_end();
        case ($urandom_range(0, 4))
            0: send_byte(CH_CR);
            1: send_byte(CH_LF);
            2: begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            3: begin
                send_byte(CH_LF);
                send_byte(CH_CR);
            end
            default: begin
                send_byte(CH_CR);
                send_byte(CH_CR);
            end
        endcase
    endtask

    initial begin
        logic [7:0]  directed[] = '{
            CH_BS, CH_DEL, CH_SPACE, CH_TILDE, 8'h41, CH_BS, CH_DEL,
            CH_CR, CH_LF, CH_LF, CH_CR, CH_CR, CH_CR,
            8'h00, 8'h1F, 8'h80, 8'hFF, 8'h61, CH_SUB, CH_SUB,
            CH_CR, 8'h00, CH_LF, 8'h7A, CH_LF
        };
        int unsigned base;
        logic        paused;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) send_byte(directed[i]);
        wait_drained();

        // Mostly typed lines with edits; the rest control bytes and noise.
        base   = sb.bytes_taken;
        paused = 1'b0;
        while (sb.bytes_taken - base < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: send_text($urandom_range(1, 12));
                11, 12, 13: send_line_end();
                14: repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
                15: send_byte(CH_SUB);
                default: repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            endcase
            if (!paused && sb.bytes_taken - base >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // One line just long enough to hit the overflow, then one more character.
        send_byte(CH_CR);
        repeat (LINE_CAPACITY - 1) send_byte(any_printable());
        send_byte(CH_LF);

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("bytes taken %0d (%0d with results), buffer overflows %0d",
                 sb.bytes_taken, sb.bytes_active, sb.overflows);
        $display("results: echo %0d, store %0d, line %0d, end of input %0d",
                 sb.kind_count[KIND_ECHO], sb.kind_count[KIND_STORE],
                 sb.kind_count[KIND_LINE], sb.kind_count[KIND_EOF]);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("serial_console_line_editor_top: match");
        end else begin
            $display("serial_console_line_editor_top: mismatch");
        end
        $finish;
    end

endmodule

### serial_console_line_editor_top.f
sv/scle_pkg.sv
sv/scle_decode.sv
sv/serial_console_line_editor_top.sv
tb/sv/tb_serial_console_line_editor_top.sv
